// ===== hw/rtl/tcld_pkg.sv =====
package tcld_pkg;

    // One input beat: a received character or a poll request.
    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_item_t;

    // One result beat, returned for every poll.
    typedef struct packed {
        logic [5:0]  command_mask;
        logic [15:0] period_ms;
        logic        connected;
    } out_item_t;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_POLL = 1'b1;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;

    localparam int NUM_WORDS   = 8;
    localparam int WORD_SLOTS  = 16;
    localparam int DIGIT_START = 7;

    localparam int             VALUE_W   = 17;
    localparam logic [16:0]    VALUE_CAP = 17'd65536;
    localparam logic [16:0]    VALUE_MAX = 17'd65535;

    // Command words in priority order.
    typedef enum logic [2:0] {
        W_CONNECT,
        W_DISCONNECT,
        W_START,
        W_STOP,
        W_PUMP_ON,
        W_PUMP_OFF,
        W_CAL,
        W_PERIOD
    } word_t;

    localparam logic [7:0] WORD_TEXT [NUM_WORDS][WORD_SLOTS] = '{
        '{"C", "O", "N", "N", "E", "C", "T", 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "I", "S", "C", "O", "N", "N", "E",
          "C", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "M", "P", " ", "O", "N", 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "M", "P", " ", "O", "F", "F",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"C", "A", "L", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "E", "R", "I", "O", "D", 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
        4'd7, 4'd10, 4'd5, 4'd4, 4'd7, 4'd8, 4'd3, 4'd6
    };

    // Pending-mask bit of each word; the link words set none.
    localparam logic [5:0] WORD_BIT [NUM_WORDS] = '{
        6'h00, 6'h00, 6'h01, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20
    };

    localparam int         CFG_INDEX_W    = 8;
    localparam logic [7:0] CFG_PERIOD_MIN = 8'd0;
    localparam logic [7:0] CFG_PERIOD_MAX = 8'd1;

    localparam logic [15:0] PERIOD_MIN_RESET = 16'd100;
    localparam logic [15:0] PERIOD_MAX_RESET = 16'd60000;

    // Line end event from the line tracker to the command status block.
    typedef struct packed {
        logic        fire;
        logic        hit;
        word_t       word;
        logic [16:0] value;
    } line_event_t;

endpackage

// ===== hw/rtl/tcld_line.sv =====
module tcld_line #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic [7:0]            rx_byte,
    output tcld_pkg::line_event_t line_event
);
    import tcld_pkg::*;

    localparam int POS_W = $clog2(LINE_CAPACITY);
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(LINE_CAPACITY - 1);

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [NUM_WORDS-1:0] flags_reg, flags_next;
    logic [VALUE_W-1:0]   digit_reg, digit_next;
    logic                 running_reg, running_next;

    logic               is_eol;
    logic               is_digit;
    logic [20:0]        digit_sum;

    assign is_eol   = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
    assign is_digit = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
    // value * 10 + digit, as two shifts and adds
    assign digit_sum = ({4'b0, digit_reg} << 3) + ({4'b0, digit_reg} << 1)
                     + {17'b0, rx_byte[3:0]};

    // Decode of the finished line: the lowest word still matching and fully seen.
    always_comb
    begin
        line_event       = '0;
        line_event.word  = W_CONNECT;
        line_event.fire  = byte_valid && is_eol && (pos_reg != '0);
        line_event.value = digit_reg;
        for (int i = NUM_WORDS - 1; i >= 0; i--)
        begin
            if (flags_reg[i] && ({{(8 - POS_W){1'b0}}, pos_reg} >= 8'(WORD_LEN[i])))
            begin
                line_event.hit  = 1'b1;
                line_event.word = word_t'(3'(i));
            end
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        flags_next   = flags_reg;
        digit_next   = digit_reg;
        running_next = running_reg;
        if (byte_valid)
        begin
            if (is_eol)
            begin
                if (pos_reg != '0)
                begin
                    pos_next     = '0;
                    flags_next   = '1;
                    digit_next   = '0;
                    running_next = 1'b1;
                end
            end
            else if (pos_reg != POS_FULL)
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    if (({{(8 - POS_W){1'b0}}, pos_reg} < 8'(WORD_LEN[i]))
                        && (WORD_TEXT[i][pos_reg[3:0]] != rx_byte))
                    begin
                        flags_next[i] = 1'b0;
                    end
                end
                if (({{(8 - POS_W){1'b0}}, pos_reg} >= 8'(DIGIT_START)) && running_reg)
                begin
                    if (is_digit)
                    begin
                        if (digit_sum > {4'b0, VALUE_MAX})
                        begin
                            digit_next = VALUE_CAP;
                        end
                        else
                        begin
                            digit_next = digit_sum[VALUE_W-1:0];
                        end
                    end
                    else
                    begin
                        running_next = 1'b0;
                    end
                end
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            flags_reg   <= '1;
            digit_reg   <= '0;
            running_reg <= 1'b1;
        end
        else
        begin
            pos_reg     <= pos_next;
            flags_reg   <= flags_next;
            digit_reg   <= digit_next;
            running_reg <= running_next;
        end
    end

endmodule

// ===== hw/rtl/tcld_status.sv =====
module tcld_status (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tcld_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [15:0]                          cfg_data,
    input  tcld_pkg::line_event_t                line_event,
    input  logic                                 poll,
    output tcld_pkg::out_item_t                  status
);
    import tcld_pkg::*;

    logic [15:0] period_min_reg, period_min_next;
    logic [15:0] period_max_reg, period_max_next;
    logic [5:0]  pending_reg, pending_next;
    logic [15:0] period_reg, period_next;
    logic        link_reg, link_next;

    logic        in_limits;

    assign in_limits = (line_event.value >= {1'b0, period_min_reg})
                    && (line_event.value <= {1'b0, period_max_reg});

    always_comb
    begin
        period_min_next = period_min_reg;
        period_max_next = period_max_reg;
        if (cfg_write)
        begin
            if (cfg_index == CFG_PERIOD_MIN)
            begin
                period_min_next = cfg_data;
            end
            else if (cfg_index == CFG_PERIOD_MAX)
            begin
                period_max_next = cfg_data;
            end
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        period_next  = period_reg;
        link_next    = link_reg;
        if (poll)
        begin
            pending_next = '0;
        end
        else if (line_event.fire && line_event.hit)
        begin
            unique case (line_event.word)
                W_CONNECT:    link_next = 1'b1;
                W_DISCONNECT: link_next = 1'b0;
                W_PERIOD:
                begin
                    if (in_limits)
                    begin
                        period_next  = line_event.value[15:0];
                        pending_next = pending_reg | WORD_BIT[W_PERIOD];
                    end
                end
                default:      pending_next = pending_reg | WORD_BIT[line_event.word];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_min_reg <= PERIOD_MIN_RESET;
            period_max_reg <= PERIOD_MAX_RESET;
            pending_reg    <= '0;
            period_reg     <= '0;
            link_reg       <= 1'b0;
        end
        else
        begin
            period_min_reg <= period_min_next;
            period_max_reg <= period_max_next;
            pending_reg    <= pending_next;
            period_reg     <= period_next;
            link_reg       <= link_next;
        end
    end

    assign status.command_mask = pending_reg;
    assign status.period_ms    = period_reg;
    assign status.connected    = link_reg;

endmodule

// ===== hw/rtl/text_command_line_decoder.sv =====
// Text command line decoder. Each input beat is either one received character or a poll.
// Characters are gathered into lines ending at CR or LF and matched, one character per
// cycle, against CONNECT, DISCONNECT, START, STOP, PUMP ON, PUMP OFF, CAL and PERIOD
// (first match in that order wins); empty lines are ignored and characters past
// LINE_CAPACITY-1 are dropped. A PERIOD value is kept only if it lies within
// period_min_ms..period_max_ms. Each poll returns one beat with the pending command mask,
// the last accepted period and the link flag, and clears the mask; characters return
// nothing. The block takes one beat per cycle while not stalled: a beat is held in the input
// register and decoded there, and a poll result is written to the output register when
// the beat leaves the input register. Input stalls only when a poll waits behind an
// output beat that has not been taken.
module text_command_line_decoder #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tcld_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tcld_pkg::out_item_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcld_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data
);
    import tcld_pkg::*;

    logic       in_valid_reg, in_valid_next;
    in_item_t   in_item_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg;

    logic        advance;
    logic        poll;
    logic        byte_valid;
    line_event_t line_event;
    out_item_t   status;

    // A character never waits; a poll waits only for room in the output register.
    assign advance = in_valid_reg
                  && ((in_item_reg.action == ACTION_BYTE) || !out_valid_reg || out_ready);
    assign in_ready   = !in_valid_reg || advance;
    assign poll       = advance && (in_item_reg.action == ACTION_POLL);
    assign byte_valid = advance && (in_item_reg.action == ACTION_BYTE);
    assign cfg_ready  = 1'b1;

    tcld_line #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .rx_byte    (in_item_reg.rx_byte),
        .line_event (line_event)
    );

    tcld_status u_status (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .line_event (line_event),
        .poll       (poll),
        .status     (status)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (poll)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (poll)
        begin
            out_item_reg <= status;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule
